### rtl/tcw_pkg.sv
// Shared types and constants of the text console tile writer.
// No dependencies; used by the top level and the checker.
package tcw_pkg;

  localparam int unsigned COLUMNS    = 40;
  localparam int unsigned TILE_ROWS  = 30;
  localparam int unsigned STORE_SIZE = COLUMNS * TILE_ROWS;

  // Widths fixed by the item fields.
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned TADDR_W = 11;

  // Store addressing: ADDR_W indexes the store, CNT_W can also hold its size,
  // IDX_W holds an unwrapped write position (below twice the store size).
  localparam int unsigned ADDR_W = $clog2(STORE_SIZE);
  localparam int unsigned CNT_W  = $clog2(STORE_SIZE + 1);
  localparam int unsigned IDX_W  = $clog2(2 * STORE_SIZE);
  localparam int unsigned RC_W   = ROW_W + 1;

  // Text rows, scroll span and used region for single and double height.
  localparam int unsigned TEXT_ROWS_S = TILE_ROWS;
  localparam int unsigned TEXT_ROWS_D = TILE_ROWS / 2;
  localparam int unsigned SPAN_S      = COLUMNS;
  localparam int unsigned SPAN_D      = 2 * COLUMNS;
  localparam int unsigned USED_S      = TEXT_ROWS_S * SPAN_S;
  localparam int unsigned USED_D      = TEXT_ROWS_D * SPAN_D;

  localparam logic [CODE_W-1:0] BLANK_S     = 8'd32;
  localparam logic [CODE_W-1:0] BLANK_D     = 8'd64;
  localparam logic [CODE_W-1:0] PRINT_FIRST = 8'd32;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [CODE_W-1:0]  char_code;
    logic [TADDR_W-1:0] tile_address;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] tile_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } out_t;

endpackage

### rtl/tcw_tile_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module tcw_tile_ram #(
  parameter int unsigned DEPTH = 1200,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/text_console_tile_writer_unit.sv
// Text console tile writer: top level with the cursor, the sequencer and the tile RAM.
// Depends on tcw_pkg and tcw_tile_ram.
//
// Usage: after reset the block sweeps the tile store to zero, one tile per cycle,
// with busy high. An item is taken when start is high and busy is low; its one
// result appears on out_data for one cycle with out_valid and cannot be held off.
// A read passes through ST_READ; a printable character through ST_PUT, ST_WR1,
// ST_WR2 (double height only) and ST_ADV; a line break through ST_ADV alone.
// When the cursor leaves the last text row the map scrolls through the tile RAM's
// read and write ports, one tile per cycle, before the result is given.
// Configuration beats are always accepted.
module text_console_tile_writer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tcw_pkg::in_t  in_data,
  output logic          out_valid,
  output tcw_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_WR1,
    ST_WR2,
    ST_ADV,
    ST_MOVE
  } state_t;

  // The move and fill phases of a scroll share the move state; this phase tells them apart.
  typedef enum logic {
    PH_MOVE,
    PH_FILL
  } phase_t;

  state_t              state_r;
  phase_t              phase_r;
  logic [CNT_W-1:0]    ptr_r;
  logic                dbl_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic                brk_r;
  logic                rd_ok_r;
  logic [CODE_W-1:0]   val_r;
  logic [ADDR_W-1:0]   idx_r;
  logic                mv_vld_r;
  logic [ADDR_W-1:0]   mv_dst_r;
  logic                out_valid_r;
  out_t                out_data_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CODE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CODE_W-1:0]   ram_rdata;

  logic                accept;
  logic                addr_ok;
  logic [RC_W-1:0]     text_rows;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    used;
  logic [CODE_W-1:0]   blank;
  logic [IDX_W-1:0]    row_base;
  logic [IDX_W-1:0]    idx_raw;
  logic [IDX_W-1:0]    idx_wrap;
  logic [IDX_W-1:0]    idx2_raw;
  logic [IDX_W-1:0]    idx2_wrap;
  logic [COL_W:0]      col_inc;
  logic [RC_W-1:0]     row_inc;
  logic                wrap_line;
  logic                need_scroll;
  logic [COL_W-1:0]    col_adv;
  logic [ROW_W-1:0]    row_adv;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign addr_ok   = (32'(in_data.tile_address) < 32'(STORE_SIZE));

  assign text_rows = dbl_r ? RC_W'(TEXT_ROWS_D) : RC_W'(TEXT_ROWS_S);
  assign span      = dbl_r ? CNT_W'(SPAN_D) : CNT_W'(SPAN_S);
  assign used      = dbl_r ? CNT_W'(USED_D) : CNT_W'(USED_S);
  assign blank     = dbl_r ? BLANK_D : BLANK_S;

  // Write position of the cursor; the sum stays below twice the store size.
  assign row_base  = IDX_W'(row_r) * IDX_W'(COLUMNS);
  assign idx_raw   = IDX_W'(col_r) + (dbl_r ? (row_base << 1) : row_base);
  assign idx_wrap  = (idx_raw >= IDX_W'(STORE_SIZE)) ? idx_raw - IDX_W'(STORE_SIZE) : idx_raw;
  assign idx2_raw  = IDX_W'(idx_r) + IDX_W'(COLUMNS);
  assign idx2_wrap = (idx2_raw >= IDX_W'(STORE_SIZE)) ? idx2_raw - IDX_W'(STORE_SIZE)
                                                      : idx2_raw;

  // Cursor advance after a character or a line break.
  assign col_inc     = {1'b0, col_r} + 1'b1;
  assign row_inc     = {1'b0, row_r} + 1'b1;
  assign wrap_line   = brk_r || (32'(col_inc) >= 32'(COLUMNS));
  assign need_scroll = wrap_line && (row_inc >= text_rows);
  assign col_adv     = wrap_line ? '0 : col_inc[COL_W-1:0];
  assign row_adv     = !wrap_line ? row_r :
                       need_scroll ? ROW_W'(text_rows - 1'b1) : row_inc[ROW_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r[ADDR_W-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr_r[ADDR_W-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_re    = accept && (in_data.operation == OP_READ) && addr_ok;
        ram_raddr = ADDR_W'(in_data.tile_address);
      end
      ST_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = val_r;
      end
      ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = idx2_wrap[ADDR_W-1:0];
        ram_wdata = val_r + 1'b1;
      end
      ST_MOVE: begin
        if (phase_r == PH_MOVE) begin
          // Reads run ahead of writes by one text row, so no tile is read after
          // it has been overwritten.
          ram_re    = (ptr_r < used);
          ram_we    = mv_vld_r;
          ram_waddr = mv_dst_r;
          ram_wdata = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = blank;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= PH_MOVE;
      ptr_r       <= '0;
      dbl_r       <= 1'b1;
      col_r       <= '0;
      row_r       <= '0;
      mv_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        dbl_r <= cfg_data;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (ptr_r == CNT_W'(STORE_SIZE - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            brk_r   <= 1'b0;
            rd_ok_r <= addr_ok;
            val_r   <= dbl_r ? {in_data.char_code[CODE_W-2:0], 1'b0} : in_data.char_code;
            if (in_data.operation == OP_READ) begin
              state_r <= ST_READ;
            end else if (in_data.char_code < PRINT_FIRST) begin
              brk_r   <= 1'b1;
              val_r   <= '0;
              state_r <= ST_ADV;
            end else begin
              state_r <= ST_PUT;
            end
          end
        end
        ST_READ: begin
          out_valid_r           <= 1'b1;
          out_data_r.tile_value <= rd_ok_r ? ram_rdata : '0;
          out_data_r.cursor_col <= col_r;
          out_data_r.cursor_row <= row_r;
          state_r               <= ST_IDLE;
        end
        ST_PUT: begin
          idx_r   <= idx_wrap[ADDR_W-1:0];
          state_r <= ST_WR1;
        end
        ST_WR1: begin
          state_r <= dbl_r ? ST_WR2 : ST_ADV;
        end
        ST_WR2: begin
          state_r <= ST_ADV;
        end
        ST_ADV: begin
          col_r <= col_adv;
          row_r <= row_adv;
          if (need_scroll) begin
            phase_r  <= PH_MOVE;
            ptr_r    <= span;
            mv_vld_r <= 1'b0;
            state_r  <= ST_MOVE;
          end else begin
            out_valid_r           <= 1'b1;
            out_data_r.tile_value <= val_r;
            out_data_r.cursor_col <= col_adv;
            out_data_r.cursor_row <= row_adv;
            state_r               <= ST_IDLE;
          end
        end
        ST_MOVE: begin
          if (phase_r == PH_MOVE) begin
            if (ptr_r < used) begin
              ptr_r    <= ptr_r + 1'b1;
              mv_vld_r <= 1'b1;
              mv_dst_r <= ADDR_W'(ptr_r - span);
            end else begin
              mv_vld_r <= 1'b0;
              if (!mv_vld_r) begin
                phase_r <= PH_FILL;
                ptr_r   <= used - span;
              end
            end
          end else if (ptr_r == used - 1'b1) begin
            out_valid_r           <= 1'b1;
            out_data_r.tile_value <= val_r;
            out_data_r.cursor_col <= col_r;
            out_data_r.cursor_row <= row_r;
            state_r               <= ST_IDLE;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  tcw_tile_ram #(
    .DEPTH (STORE_SIZE),
    .WIDTH (CODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/tcw_checker.sv
// Port-level checks on the text console tile writer, and the bind that attaches them.
// Depends on tcw_pkg and text_console_tile_writer_unit.
module tcw_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input tcw_pkg::out_t out_data
);
  import tcw_pkg::*;

  // An accepted beat always makes the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  // A result closes the item that produced it.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result without a preceding busy period");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((32'(out_data.cursor_col) < 32'(COLUMNS)) &&
                   (32'(out_data.cursor_row) < 32'(TILE_ROWS))))
    else $error("cursor outside the tile map");

endmodule

bind text_console_tile_writer_unit tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
